// ===== hw/rtl/lr_eval_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LR expression evaluator package
// Word types, token and status codes, the LALR action and goto tables and
// the microcode program of the evaluator sequencer.
// ----------------------------------------------------------------------------
package lr_eval_pkg;

   // Stack geometry and value width
   localparam int STACK_DEPTH = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int SP_WIDTH    = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
   localparam int PS_WIDTH    = 4;
   localparam int STEP_WIDTH  = 3;

   // Reduction lengths
   localparam logic [1:0] LEN_NONE   = 2'd0;
   localparam logic [1:0] LEN_SINGLE = 2'd1;
   localparam logic [1:0] LEN_BINARY = 2'd3;

   // Token kinds
   localparam logic [2:0] TK_INT     = 3'd0;
   localparam logic [2:0] TK_PLUS    = 3'd1;
   localparam logic [2:0] TK_TIMES   = 3'd2;
   localparam logic [2:0] TK_OPEN    = 3'd3;
   localparam logic [2:0] TK_CLOSE   = 3'd4;
   localparam logic [2:0] TK_END     = 3'd5;

   // Result status codes
   localparam logic [2:0] STATUS_CONSUMED = 3'd0;
   localparam logic [2:0] STATUS_ACCEPTED = 3'd1;
   localparam logic [2:0] STATUS_SKIPPED  = 3'd2;
   localparam logic [2:0] STATUS_FATAL    = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

   // Parser states
   localparam logic [PS_WIDTH-1:0] PS_START   = 4'd0;
   localparam logic [PS_WIDTH-1:0] PS_EXPR    = 4'd1;
   localparam logic [PS_WIDTH-1:0] PS_OPEN    = 4'd2;
   localparam logic [PS_WIDTH-1:0] PS_INT     = 4'd3;
   localparam logic [PS_WIDTH-1:0] PS_PLUS    = 4'd4;
   localparam logic [PS_WIDTH-1:0] PS_TIMES   = 4'd5;
   localparam logic [PS_WIDTH-1:0] PS_INNER   = 4'd6;
   localparam logic [PS_WIDTH-1:0] PS_SUM     = 4'd7;
   localparam logic [PS_WIDTH-1:0] PS_PRODUCT = 4'd8;
   localparam logic [PS_WIDTH-1:0] PS_PAREN   = 4'd9;
   localparam logic [PS_WIDTH-1:0] PS_NONE    = 4'hF;

   // Microcode steps
   localparam logic [STEP_WIDTH-1:0] STEP_FETCH  = 3'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_DECODE = 3'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_SHIFT  = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_ACCEPT = 3'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_REDUCE = 3'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_ERROR  = 3'd5;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [31:0] token_value;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] result_value;
      logic [3:0]  error_state;
   } rsp_word_type;

   // Parser action; order matches the step order from STEP_SHIFT on
   typedef enum logic [1:0] {
      ACT_SHIFT,
      ACT_ACCEPT,
      ACT_REDUCE,
      ACT_ERROR
   } act_type;

   typedef struct packed {
      act_type             act;
      logic [PS_WIDTH-1:0] next_state;
      logic [1:0]          rlen;
   } action_type;

   // Datapath operation of one step
   typedef enum logic [2:0] {
      OP_FETCH,
      OP_DECODE,
      OP_SHIFT,
      OP_ACCEPT,
      OP_REDUCE,
      OP_ERROR
   } op_type;

   // Jump condition of one step
   typedef enum logic [1:0] {
      JC_TOKEN,
      JC_DISPATCH,
      JC_SLOT,
      JC_GOTO
   } jc_type;

   typedef struct packed {
      op_type                op;
      jc_type                jc;
      logic [STEP_WIDTH-1:0] target;
   } ucode_type;

   // Action table of the LALR automaton
   function automatic action_type lr_action(input logic [PS_WIDTH-1:0] st,
                                            input logic [2:0] kind);
      action_type a;
      logic       follow;
      begin
         a = '{act: ACT_ERROR, next_state: PS_NONE, rlen: LEN_NONE};
         follow = (kind == TK_PLUS) || (kind == TK_TIMES) ||
                  (kind == TK_CLOSE) || (kind == TK_END);
         case (st)
            PS_START, PS_OPEN, PS_PLUS, PS_TIMES: begin
               if (kind == TK_INT) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_INT;
               end else if (kind == TK_OPEN) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_OPEN;
               end
            end
            PS_EXPR: begin
               if (kind == TK_PLUS) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_PLUS;
               end else if (kind == TK_TIMES) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_TIMES;
               end else if (kind == TK_END) begin
                  a.act = ACT_ACCEPT;
               end
            end
            PS_INT: begin
               if (follow) begin
                  a.act = ACT_REDUCE;
                  a.rlen = LEN_SINGLE;
               end
            end
            PS_INNER: begin
               if (kind == TK_PLUS) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_PLUS;
               end else if (kind == TK_TIMES) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_TIMES;
               end else if (kind == TK_CLOSE) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_PAREN;
               end
            end
            PS_SUM: begin
               if (kind == TK_TIMES) begin
                  a.act = ACT_SHIFT;
                  a.next_state = PS_TIMES;
               end else if (follow) begin
                  a.act = ACT_REDUCE;
                  a.rlen = LEN_BINARY;
               end
            end
            PS_PRODUCT, PS_PAREN: begin
               if (follow) begin
                  a.act = ACT_REDUCE;
                  a.rlen = LEN_BINARY;
               end
            end
            default: begin
               a.act = ACT_ERROR;
            end
         endcase
         return a;
      end
   endfunction

   // Goto on E; PS_NONE where the exposed state has no entry
   function automatic logic [PS_WIDTH-1:0] lr_goto(input logic [PS_WIDTH-1:0] st);
      case (st)
         PS_START: return PS_EXPR;
         PS_OPEN:  return PS_INNER;
         PS_PLUS:  return PS_SUM;
         PS_TIMES: return PS_PRODUCT;
         default:  return PS_NONE;
      endcase
   endfunction

   // Microcode program
   function automatic ucode_type lr_ucode(input logic [STEP_WIDTH-1:0] step);
      case (step)
         STEP_FETCH:  return '{op: OP_FETCH,  jc: JC_TOKEN,    target: STEP_DECODE};
         STEP_DECODE: return '{op: OP_DECODE, jc: JC_DISPATCH, target: STEP_SHIFT};
         STEP_SHIFT:  return '{op: OP_SHIFT,  jc: JC_SLOT,     target: STEP_FETCH};
         STEP_ACCEPT: return '{op: OP_ACCEPT, jc: JC_SLOT,     target: STEP_FETCH};
         STEP_REDUCE: return '{op: OP_REDUCE, jc: JC_GOTO,     target: STEP_DECODE};
         STEP_ERROR:  return '{op: OP_ERROR,  jc: JC_SLOT,     target: STEP_FETCH};
         default:     return '{op: OP_FETCH,  jc: JC_TOKEN,    target: STEP_DECODE};
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lr_expression_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LR expression evaluator
// Shift-reduce evaluator for integer expressions over +, * and parentheses,
// run by a microcoded sequencer over state and value stacks in RAM.
// ----------------------------------------------------------------------------
// Feed one token per request word; every token yields exactly one response
// word (consumed, accepted with the expression value, skipped, fatal error or
// stack overflow). A token runs through fetch, decode and then shift or finish,
// with a reduce and a further decode for each reduction it triggers; the
// stack RAM read of each reduction is issued in decode and used in reduce.
// Only one token is in work at a time; a finished response waits
// in the output register while the next token is taken. After accept, fatal
// error or overflow the stacks start over with only the start state. No
// clearing pass runs after reset: the stack pointer bounds what is read, and
// the bottom entry is always read as the start state.
module lr_expression_evaluator
   import lr_eval_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   // Control registers
   logic [STEP_WIDTH-1:0]  step_ff,       step_in;
   logic [SP_WIDTH-1:0]    sp_ff,         sp_in;
   logic [PS_WIDTH-1:0]    top_state_ff,  top_state_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   // Payload registers
   logic [VALUE_WIDTH-1:0] top_value_ff,  top_value_in;
   logic [2:0]             kind_ff,       kind_in;
   logic [VALUE_WIDTH-1:0] tval_ff,       tval_in;
   logic [1:0]             rlen_ff,       rlen_in;
   logic                   fatal_ff,      fatal_in;
   logic                   bottom_ff,     bottom_in;
   rsp_word_type           rsp_word_ff,   rsp_word_in;

   ucode_type              uc;
   action_type             act;
   act_type                eff_act;
   logic                   slot_free;
   logic                   overflow;
   logic [SP_WIDTH-1:0]    rd_state_ptr;
   logic [SP_WIDTH-1:0]    rd_value_ptr;
   logic [SP_WIDTH-1:0]    red_sp;
   logic [PS_WIDTH-1:0]    under_state;
   logic [PS_WIDTH-1:0]    goto_state;
   logic                   goto_ok;
   logic [VALUE_WIDTH-1:0] red_value;
   logic [PS_WIDTH-1:0]    state_rdata;
   logic [VALUE_WIDTH-1:0] value_rdata;
   logic                   wr_en;
   logic [ADDR_WIDTH-1:0]  wr_addr;
   logic [PS_WIDTH-1:0]    wr_state;
   logic [VALUE_WIDTH-1:0] wr_value;

   // Stack memories
   lr_eval_ram #(.WIDTH(PS_WIDTH), .DEPTH(STACK_DEPTH)) u_state_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_state),
      .rd_addr (rd_state_ptr[ADDR_WIDTH-1:0]),
      .rd_data (state_rdata)
   );

   lr_eval_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_value_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_value),
      .rd_addr (rd_value_ptr[ADDR_WIDTH-1:0]),
      .rd_data (value_rdata)
   );

   // Decode the current step and parser action
   assign uc        = lr_ucode(step_ff);
   assign act       = lr_action(top_state_ff, kind_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign overflow  = (sp_ff >= SP_WIDTH'(STACK_DEPTH));

   // Reduce only with enough entries below the top
   always_comb begin
      eff_act = act.act;
      if (act.act == ACT_REDUCE && !(sp_ff > SP_WIDTH'(act.rlen))) begin
         eff_act = ACT_ERROR;
      end
   end

   // Read pointers: state exposed by the reduction, and the left operand (or the inner value of a paren)
   assign rd_state_ptr = sp_ff - SP_WIDTH'(1) - SP_WIDTH'(act.rlen);
   assign rd_value_ptr = (top_state_ff == PS_PAREN) ? (sp_ff - SP_WIDTH'(2))
                                                    : (sp_ff - SP_WIDTH'(3));

   // Reduction result and goto
   assign red_sp      = sp_ff - SP_WIDTH'(rlen_ff);
   assign under_state = bottom_ff ? PS_START : state_rdata;
   assign goto_state  = lr_goto(under_state);
   assign goto_ok     = (goto_state != PS_NONE);

   always_comb begin
      case (top_state_ff)
         PS_INT:     red_value = top_value_ff;
         PS_SUM:     red_value = value_rdata + top_value_ff;
         PS_PRODUCT: red_value = VALUE_WIDTH'(value_rdata * top_value_ff);
         default:    red_value = value_rdata;
      endcase
   end

   // Datapath and sequencer next values
   always_comb begin
      step_in      = step_ff;
      sp_in        = sp_ff;
      top_state_in = top_state_ff;
      top_value_in = top_value_ff;
      kind_in      = kind_ff;
      tval_in      = tval_ff;
      rlen_in      = rlen_ff;
      fatal_in     = fatal_ff;
      bottom_in    = bottom_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_state     = '0;
      wr_value     = '0;

      case (uc.op)
         OP_FETCH: begin
            if (req_valid) begin
               kind_in = req_word.token_kind;
               tval_in = VALUE_WIDTH'(req_word.token_value);
            end
         end
         OP_DECODE: begin
            rlen_in   = act.rlen;
            fatal_in  = (kind_ff == TK_INT) || (kind_ff == TK_END) ||
                        (act.rlen != LEN_NONE);
            bottom_in = (rd_state_ptr == '0);
         end
         OP_SHIFT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (overflow) begin
                  sp_in        = SP_WIDTH'(1);
                  top_state_in = PS_START;
                  rsp_word_in  = '{status: STATUS_OVERFLOW, result_value: '0,
                                   error_state: top_state_ff};
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = sp_ff[ADDR_WIDTH-1:0];
                  wr_state     = act.next_state;
                  wr_value     = (kind_ff == TK_INT) ? tval_ff : '0;
                  sp_in        = sp_ff + SP_WIDTH'(1);
                  top_state_in = act.next_state;
                  top_value_in = wr_value;
                  rsp_word_in  = '{status: STATUS_CONSUMED, result_value: '0,
                                   error_state: '0};
               end
            end
         end
         OP_ACCEPT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               sp_in        = SP_WIDTH'(1);
               top_state_in = PS_START;
               rsp_word_in  = '{status: STATUS_ACCEPTED,
                                result_value: 32'(top_value_ff), error_state: '0};
            end
         end
         OP_REDUCE: begin
            if (goto_ok) begin
               wr_en        = 1'b1;
               wr_addr      = red_sp[ADDR_WIDTH-1:0];
               wr_state     = goto_state;
               wr_value     = red_value;
               sp_in        = red_sp + SP_WIDTH'(1);
               top_state_in = goto_state;
               top_value_in = red_value;
            end else begin
               fatal_in = 1'b1;
            end
         end
         OP_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (fatal_ff) begin
                  sp_in        = SP_WIDTH'(1);
                  top_state_in = PS_START;
                  rsp_word_in  = '{status: STATUS_FATAL, result_value: '0,
                                   error_state: top_state_ff};
               end else begin
                  rsp_word_in  = '{status: STATUS_SKIPPED, result_value: '0,
                                   error_state: top_state_ff};
               end
            end
         end
         default: begin
            step_in = STEP_FETCH;
         end
      endcase

      // Advance the step counter
      case (uc.jc)
         JC_TOKEN: begin
            if (req_valid) begin
               step_in = uc.target;
            end
         end
         JC_DISPATCH: begin
            step_in = uc.target + STEP_WIDTH'(eff_act);
         end
         JC_SLOT: begin
            if (slot_free) begin
               step_in = uc.target;
            end
         end
         JC_GOTO: begin
            step_in = goto_ok ? uc.target : STEP_ERROR;
         end
         default: begin
            step_in = STEP_FETCH;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_FETCH;
         sp_ff        <= SP_WIDTH'(1);
         top_state_ff <= PS_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         sp_ff        <= sp_in;
         top_state_ff <= top_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_value_ff <= top_value_in;
      kind_ff      <= kind_in;
      tval_ff      <= tval_in;
      rlen_ff      <= rlen_in;
      fatal_ff     <= fatal_in;
      bottom_ff    <= bottom_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign req_stall = (step_ff != STEP_FETCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Stack pointer never leaves its range
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      (sp_ff >= SP_WIDTH'(1)) && (sp_ff <= SP_WIDTH'(STACK_DEPTH)))
      else $error("stack pointer out of range");

   // Start state sits only at the bottom
   a_start_bottom: assert property (@(posedge clock) disable iff (reset)
      (sp_ff == SP_WIDTH'(1)) == (top_state_ff == PS_START))
      else $error("start state and stack pointer disagree");

   // A reduction always has its operands on the stack
   a_reduce_depth: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_REDUCE) |-> (rlen_ff != LEN_NONE) &&
      (sp_ff > SP_WIDTH'(rlen_ff)))
      else $error("reduction without enough stack entries");

   // A response appears only out of a finishing step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(step_ff) == STEP_SHIFT) ||
      ($past(step_ff) == STEP_ACCEPT) || ($past(step_ff) == STEP_ERROR))
      else $error("response word from a non-finishing step");

endmodule
`default_nettype wire

// ===== hw/rtl/lr_eval_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lr_eval_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== tb/sv/lr_expression_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LR expression evaluator testbench
// Feeds token words to the shift-reduce evaluator and checks every response
// word against a parser model kept in the bench. Directed tests cover
// literals, precedence, wraparound, syntax errors and stack overflow. Random
// expressions with noise follow, under several sender and receiver idling
// mixes.
// ----------------------------------------------------------------------------
module lr_expression_evaluator_tb;
   import lr_eval_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // Parser model state
   logic [PS_WIDTH-1:0]    model_states [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] model_values [STACK_DEPTH];
   int                     model_depth;

   rsp_word_type expected_words [$];
   rsp_word_type expected_head;
   int           error_count = 0;
   int           words_sent = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;

   lr_expression_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Drop both stacks back to the start state
   function automatic void clear_model();
      model_depth = 1;
      model_states[0] = PS_START;
   endfunction

   // Run the parser on one token: reduce until it shifts, accepts or errs
   function automatic rsp_word_type evaluate_token(input req_word_type w);
      rsp_word_type        r;
      logic [2:0]          kind;
      logic [PS_WIDTH-1:0] top, shift_to, exposed, goto_state;
      logic [1:0]          rlen;
      logic                follow, accepts;
      logic [31:0]         v;
      int                  sp;
      r = '0;
      kind = w.token_kind;
      follow = (kind == TK_PLUS) || (kind == TK_TIMES) || (kind == TK_CLOSE) ||
               (kind == TK_END);
      for (int guard = 0; guard < 2 * STACK_DEPTH + 8; guard++) begin
         sp = model_depth;
         top = model_states[sp - 1];
         shift_to = PS_NONE;
         rlen = LEN_NONE;
         accepts = 1'b0;
         case (top)
            PS_START, PS_OPEN, PS_PLUS, PS_TIMES: begin
               if (kind == TK_INT) shift_to = PS_INT;
               else if (kind == TK_OPEN) shift_to = PS_OPEN;
            end
            PS_EXPR: begin
               if (kind == TK_PLUS) shift_to = PS_PLUS;
               else if (kind == TK_TIMES) shift_to = PS_TIMES;
               else if (kind == TK_END) accepts = 1'b1;
            end
            PS_INT: begin
               if (follow) rlen = LEN_SINGLE;
            end
            PS_INNER: begin
               if (kind == TK_PLUS) shift_to = PS_PLUS;
               else if (kind == TK_TIMES) shift_to = PS_TIMES;
               else if (kind == TK_CLOSE) shift_to = PS_PAREN;
            end
            PS_SUM: begin
               if (kind == TK_TIMES) shift_to = PS_TIMES;
               else if (follow) rlen = LEN_BINARY;
            end
            PS_PRODUCT, PS_PAREN: begin
               if (follow) rlen = LEN_BINARY;
            end
            default: begin
            end
         endcase

         if (accepts) begin
            r.status = STATUS_ACCEPTED;
            r.result_value = model_values[sp - 1];
            clear_model();
            return r;
         end
         if (shift_to != PS_NONE) begin
            if (sp >= STACK_DEPTH) begin
               clear_model();
               r.status = STATUS_OVERFLOW;
               r.error_state = top;
               return r;
            end
            model_states[sp] = shift_to;
            model_values[sp] = (kind == TK_INT) ? w.token_value : '0;
            model_depth = sp + 1;
            r.status = STATUS_CONSUMED;
            return r;
         end
         if (rlen != LEN_NONE && sp > int'(rlen)) begin
            // Reduce: fold the handle into one value, then goto on E
            case (top)
               PS_INT:     v = model_values[sp - 1];
               PS_SUM:     v = model_values[sp - 3] + model_values[sp - 1];
               PS_PRODUCT: v = model_values[sp - 3] * model_values[sp - 1];
               default:    v = model_values[sp - 2];
            endcase
            sp = sp - int'(rlen);
            exposed = model_states[sp - 1];
            case (exposed)
               PS_START: goto_state = PS_EXPR;
               PS_OPEN:  goto_state = PS_INNER;
               PS_PLUS:  goto_state = PS_SUM;
               PS_TIMES: goto_state = PS_PRODUCT;
               default:  goto_state = PS_NONE;
            endcase
            if (goto_state == PS_NONE) begin
               clear_model();
               r.status = STATUS_FATAL;
               r.error_state = top;
               return r;
            end
            model_states[sp] = goto_state;
            model_values[sp] = v;
            model_depth = sp + 1;
         end else begin
            // Syntax error: int, end or a reduction short of entries is fatal, anything else is dropped
            r.error_state = top;
            if (kind == TK_INT || kind == TK_END || rlen != LEN_NONE) begin
               clear_model();
               r.status = STATUS_FATAL;
            end else begin
               r.status = STATUS_SKIPPED;
            end
            return r;
         end
      end
      clear_model();
      r.status = STATUS_FATAL;
      return r;
   endfunction

   // Send one token word, with random idle cycles ahead of it
   task automatic send_token(input logic [2:0] kind, input logic [31:0] value);
      req_word_type w;
      w.token_kind = kind;
      w.token_value = value;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_word = req_word_type'({$urandom, $urandom});
         @(posedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_word = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(evaluate_token(w));
      words_sent++;
   endtask

   // Compare each accepted response word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected response word %h", rsp_word);
            error_count++;
         end else begin
            expected_head = expected_words.pop_front();
            if (rsp_word.status !== expected_head.status) begin
               $error("status: expected %0d, got %0d", expected_head.status,
                      rsp_word.status);
               error_count++;
            end
            if (rsp_word.result_value !== expected_head.result_value) begin
               $error("result_value: expected %0h, got %0h",
                      expected_head.result_value, rsp_word.result_value);
               error_count++;
            end
            if (rsp_word.error_state !== expected_head.error_state) begin
               $error("error_state: expected %0d, got %0d",
                      expected_head.error_state, rsp_word.error_state);
               error_count++;
            end
         end
      end
   end

   task automatic test_single_literals();
      send_token(TK_INT, 32'd0);
      send_token(TK_END, 32'hFFFF_FFFF);
      send_token(TK_INT, 32'hFFFF_FFFF);
      send_token(TK_END, 32'd0);
   endtask

   task automatic test_precedence();
      // 2 + 3 * 4, then (2 + 3) * 4
      send_token(TK_INT, 32'd2);
      send_token(TK_PLUS, 32'd0);
      send_token(TK_INT, 32'd3);
      send_token(TK_TIMES, 32'd0);
      send_token(TK_INT, 32'd4);
      send_token(TK_END, 32'd0);
      send_token(TK_OPEN, 32'd0);
      send_token(TK_INT, 32'd2);
      send_token(TK_PLUS, 32'd0);
      send_token(TK_INT, 32'd3);
      send_token(TK_CLOSE, 32'd0);
      send_token(TK_TIMES, 32'd0);
      send_token(TK_INT, 32'd4);
      send_token(TK_END, 32'd0);
      // Wrap around the value width on multiply and add
      send_token(TK_INT, 32'hFFFF_FFFF);
      send_token(TK_TIMES, 32'd0);
      send_token(TK_INT, 32'hFFFF_FFFF);
      send_token(TK_PLUS, 32'd0);
      send_token(TK_INT, 32'd2);
      send_token(TK_END, 32'd0);
   endtask

   task automatic test_syntax_errors();
      // Stray operator, unknown kinds and end at the start state
      send_token(TK_PLUS, 32'd0);
      send_token(3'd6, 32'h1234_5678);
      send_token(3'd7, 32'hFFFF_FFFF);
      send_token(TK_END, 32'd0);
      // Int after int is fatal; open paren after int is dropped
      send_token(TK_INT, 32'd1);
      send_token(TK_INT, 32'd2);
      send_token(TK_INT, 32'd5);
      send_token(TK_OPEN, 32'd0);
      // Close without open: reductions stay, the paren is dropped
      send_token(TK_PLUS, 32'd0);
      send_token(TK_INT, 32'd6);
      send_token(TK_CLOSE, 32'd0);
      send_token(TK_END, 32'd0);
   endtask

   task automatic test_stack_depth();
      // Open parens up to a full stack, then one more
      repeat (STACK_DEPTH) send_token(TK_OPEN, 32'd0);
      // Int fills the last slot; the close paren then overflows
      repeat (STACK_DEPTH - 2) send_token(TK_OPEN, 32'd0);
      send_token(TK_INT, 32'd3);
      send_token(TK_CLOSE, 32'd0);
      // Deep nesting that unwinds cleanly
      repeat (STACK_DEPTH - 3) send_token(TK_OPEN, 32'd0);
      send_token(TK_INT, 32'd11);
      repeat (STACK_DEPTH - 3) send_token(TK_CLOSE, 32'd0);
      send_token(TK_END, 32'd0);
   endtask

   // One random expression with occasional noise, cut-offs and deep nesting
   task automatic send_random_expression();
      int   depth, operands, target, max_depth, open_pct;
      bit   want_operand, deep;
      logic [31:0] literal;
      deep = ($urandom_range(39) == 0);
      max_depth = deep ? $urandom_range(STACK_DEPTH - 8, STACK_DEPTH + 2) : 3;
      open_pct = deep ? 100 : 25;
      target = $urandom_range(1, 8);
      depth = 0;
      operands = 0;
      want_operand = 1'b1;
      while (1) begin
         if ($urandom_range(99) < 4) send_token(3'($urandom_range(7)), $urandom);
         if ($urandom_range(199) == 0) break;
         if (want_operand) begin
            if (depth < max_depth && $urandom_range(99) < open_pct) begin
               send_token(TK_OPEN, $urandom);
               depth++;
            end else begin
               case ($urandom_range(7))
                  0:       literal = 32'd0;
                  1:       literal = 32'hFFFF_FFFF;
                  2:       literal = 32'h8000_0000;
                  3:       literal = $urandom;
                  default: literal = $urandom_range(9);
               endcase
               send_token(TK_INT, literal);
               operands++;
               want_operand = 1'b0;
            end
         end else if (depth > 0 && $urandom_range(99) < 35) begin
            send_token(TK_CLOSE, $urandom);
            depth--;
         end else if (depth == 0 && operands >= target) begin
            break;
         end else begin
            send_token($urandom_range(1) ? TK_PLUS : TK_TIMES, $urandom);
            want_operand = 1'b1;
         end
      end
      send_token(TK_END, $urandom);
   endtask

   task automatic test_random_traffic();
      int first;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         first = words_sent;
         while (words_sent - first < 300) send_random_expression();
      end
   endtask

   initial begin
      clear_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_literals();
      test_precedence();
      test_syntax_errors();
      test_stack_depth();
      test_random_traffic();

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("lr_expression_evaluator_tb OK");
      end else begin
         $display("lr_expression_evaluator_tb NOT OK");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #20_000_000;
      $display("lr_expression_evaluator_tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lr_eval_pkg.sv
hw/rtl/lr_eval_ram.sv
hw/rtl/lr_expression_evaluator.sv
tb/sv/lr_expression_evaluator_tb.sv
